FILE: rtl/core/crcec_pkg.sv
// shared types and constants for the crc encode and check block
`timescale 1ns / 1ps

package crcec_pkg;

  localparam int unsigned FIELD_W = 32;

  localparam logic [FIELD_W-1:0] GEN_POLY_RST = 32'h0001_1021;

  typedef enum logic [1:0] {
    ST_SCAN,
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } crcec_state_t;

  typedef struct packed {
    logic [FIELD_W-1:0] result_word;
    logic [FIELD_W-1:0] remainder_bits;
    logic               error_flag;
    logic               overflow_flag;
  } crcec_res_t;

endpackage

FILE: rtl/core/crcec_core.sv
// generator register, degree scan and bit-serial gf2 long division sequencer
`timescale 1ns / 1ps

module crcec_core #(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [crcec_pkg::FIELD_W-1:0]       cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_opcode,
  input  logic [crcec_pkg::FIELD_W-1:0]       in_data_word,
  output logic                                res_valid,
  input  logic                                res_ready,
  output crcec_pkg::crcec_res_t               res
);

  import crcec_pkg::*;

  localparam int unsigned IW = $clog2(WORD_WIDTH);
  localparam logic [IW-1:0] IDX_LAST = IW'(WORD_WIDTH - 1);
  localparam logic [WORD_WIDTH-1:0] GEN_RST = WORD_WIDTH'(GEN_POLY_RST);

  crcec_state_t          state_r, state_nxt;
  logic [WORD_WIDTH-1:0] gen_r, gen_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [IW-1:0]         deg_r, deg_nxt;
  logic [IW-1:0]         cnt_r, cnt_nxt;
  logic [WORD_WIDTH-1:0] value_r, value_nxt;
  logic [WORD_WIDTH-1:0] gen_sh_r, gen_sh_nxt;
  logic [WORD_WIDTH-1:0] base_r, base_nxt;
  logic                  opcode_r, opcode_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [WORD_WIDTH-1:0] data_w;
  logic [WORD_WIDTH-1:0] shifted;
  logic [WORD_WIDTH-1:0] rem;
  logic                  gen_zero;
  logic                  cfg_wr;

  assign data_w   = WORD_WIDTH'(in_data_word);
  assign shifted  = in_opcode ? data_w : (data_w << deg_r);
  assign gen_zero = (gen_r == '0);
  assign rem      = gen_zero ? '0 : value_r;
  assign cfg_wr   = cfg_valid && cfg_ready;

  always_comb begin
    state_nxt  = state_r;
    gen_nxt    = gen_r;
    idx_nxt    = idx_r;
    deg_nxt    = deg_r;
    cnt_nxt    = cnt_r;
    value_nxt  = value_r;
    gen_sh_nxt = gen_sh_r;
    base_nxt   = base_r;
    opcode_nxt = opcode_r;
    ovf_nxt    = ovf_r;
    in_stall   = (state_r != ST_IDLE);
    cfg_ready  = (state_r == ST_SCAN) || ((state_r == ST_IDLE) && !in_valid);
    res_valid  = 1'b0;
    unique case (state_r)
      ST_SCAN: begin
        // degree is the last set bit seen going up
        idx_nxt = idx_r + 1'b1;
        if (gen_r[idx_r]) begin
          deg_nxt = idx_r;
        end
        if (idx_r == IDX_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          opcode_nxt = in_opcode;
          value_nxt  = shifted;
          base_nxt   = shifted;
          ovf_nxt    = !in_opcode && (|(data_w & ~({WORD_WIDTH{1'b1}} >> deg_r)));
          gen_sh_nxt = gen_r << (IDX_LAST - deg_r);
          cnt_nxt    = IDX_LAST;
          state_nxt  = ST_DIV;
        end
      end
      ST_DIV: begin
        if (value_r[cnt_r]) begin
          value_nxt = value_r ^ gen_sh_r;
        end
        gen_sh_nxt = gen_sh_r >> 1;
        if (cnt_r == deg_r) begin
          state_nxt = ST_HOLD;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_HOLD: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_SCAN;
      end
    endcase
    if (cfg_wr) begin
      // new generator, rescan its degree
      gen_nxt   = WORD_WIDTH'(cfg_data);
      idx_nxt   = '0;
      deg_nxt   = '0;
      state_nxt = ST_SCAN;
    end
  end

  always_comb begin
    res.remainder_bits = FIELD_W'(rem);
    res.result_word    = FIELD_W'(opcode_r ? rem : (base_r | rem));
    res.error_flag     = opcode_r && (rem != '0);
    res.overflow_flag  = !opcode_r && ovf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SCAN;
      gen_r   <= GEN_RST;
      idx_r   <= '0;
      deg_r   <= '0;
    end else begin
      state_r <= state_nxt;
      gen_r   <= gen_nxt;
      idx_r   <= idx_nxt;
      deg_r   <= deg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    value_r  <= value_nxt;
    gen_sh_r <= gen_sh_nxt;
    base_r   <= base_nxt;
    opcode_r <= opcode_nxt;
    ovf_r    <= ovf_nxt;
  end

`ifndef ASSERT_OFF
  a_cnt_above_deg: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r >= deg_r))
    else $error("division counter went below degree");

  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_DIV))
    else $error("accepted beat did not start division");

  a_deg_is_top_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (gen_zero || ((gen_r >> deg_r) == WORD_WIDTH'(1))))
    else $error("degree does not match generator top bit");

  a_encode_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !opcode_r) |-> !res.error_flag)
    else $error("error flag raised in encode mode");

  a_rem_below_deg: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD) |-> ((rem >> deg_r) == '0))
    else $error("remainder has bits at or above degree");
`endif

endmodule

FILE: rtl/core/gf2_crc_encode_check_top.sv
// top level of the crc encoder and checker with result output register
`timescale 1ns / 1ps

// CRC encoder/checker by GF(2) long division against a programmable generator
// polynomial. After reset and after every write of the generator, a degree scan
// walks the generator one bit a cycle with in_stall high. Each beat is then
// divided one dividend bit per cycle by a single shared xor/shift unit, from
// bit WORD_WIDTH-1 down to the degree r, and its result then goes to the output
// register; the next beat is taken while that result waits there. A zero
// generator gives a zero remainder.
module gf2_crc_encode_check_top #(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_generator_poly,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [31:0] in_data_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result_word,
  output logic [31:0] out_remainder_bits,
  output logic        out_error_flag,
  output logic        out_overflow_flag
);

  import crcec_pkg::*;

  crcec_res_t res;
  crcec_res_t out_res_r;
  logic       res_valid;
  logic       res_ready;
  logic       out_valid_r, out_valid_nxt;

  crcec_core #(
    .WORD_WIDTH(WORD_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_generator_poly),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_opcode   (in_opcode),
    .in_data_word(in_data_word),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_word    = out_res_r.result_word;
  assign out_remainder_bits = out_res_r.remainder_bits;
  assign out_error_flag     = out_res_r.error_flag;
  assign out_overflow_flag  = out_res_r.overflow_flag;

endmodule
